/* rtl/bcpa_pkg.sv */
package bcpa_pkg;

  // Pool geometry.
  localparam int MAX_PAGES = 1024;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = PAGE_W + 1;
  localparam int WORD_BITS = 8;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ROWS      = MAX_PAGES / WORD_BITS;
  localparam int ROW_W     = PAGE_W - BIT_W;
  localparam logic [CNT_W-1:0] MAX_P = CNT_W'(MAX_PAGES);

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PAGE_W-1:0] page_number;
    logic [CNT_W-1:0]  page_count;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] first_page;
    logic              page_free;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_MARK_RD,
    S_MARK_WR,
    S_QRY_RD,
    S_QRY_EV,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic scan_rd;
    logic scan_ev;
    logic mark_rd;
    logic mark_wr;
    logic qry_ev;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic       free_bad;
    logic       cnt_zero;
    logic       q_oob;
    logic       pass_end;
    logic       pass2;
    logic       found;
    logic       mark_last;
  } sts_t;

endpackage

/* rtl/bcpa_ram.sv */
module bcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bcpa_datapath.sv */
module bcpa_datapath import bcpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  cmd_t             cmd,
  output sts_t             sts,
  output rsp_t             rsp
);

  logic [CNT_W-1:0]     total_pages;
  logic [CNT_W-1:0]     pool;
  req_t                 req_r;
  logic [CNT_W-1:0]     cursor;
  logic [CNT_W-1:0]     pos;
  logic [CNT_W-1:0]     run;
  logic [CNT_W-1:0]     run_start;
  logic                 pass2;
  logic [CNT_W-1:0]     mpos;
  logic [CNT_W-1:0]     mend;
  logic                 mval;
  rsp_t                 res;
  logic [ROWS-1:0]      row_valid;
  logic [ROW_W-1:0]     raddr;
  logic [ROW_W-1:0]     rd_row;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] eff_word;
  logic [WORD_BITS-1:0] mark_word;
  logic [CNT_W-1:0]     pos_next_base;
  logic [CNT_W-1:0]     mpos_next_base;
  logic [CNT_W-1:0]     scan_run;
  logic [CNT_W-1:0]     scan_start;
  logic [CNT_W-1:0]     scan_hit;
  logic                 scan_found;
  logic [CNT_W:0]       free_end;

  assign pool = (total_pages > MAX_P) ? MAX_P : total_pages;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages <= MAX_P;
    end else if (cfg_we) begin
      total_pages <= cfg_wdata;
    end
  end

  // Bitmap storage; a row never written reads as all free.
  always_comb begin
    case (1'b1)
      cmd.scan_rd: raddr = pos[PAGE_W-1:BIT_W];
      cmd.mark_rd: raddr = mpos[PAGE_W-1:BIT_W];
      default:     raddr = req_r.page_number[PAGE_W-1:BIT_W];
    endcase
  end

  bcpa_ram #(.WIDTH(WORD_BITS), .DEPTH(ROWS)) u_map (
    .clk   (clk),
    .we    (cmd.mark_wr),
    .waddr (mpos[PAGE_W-1:BIT_W]),
    .wdata (mark_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    rd_row <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.mark_wr) begin
      row_valid[mpos[PAGE_W-1:BIT_W]] <= 1'b1;
    end
  end

  assign eff_word = row_valid[rd_row] ? rdata : '1;

  assign pos_next_base  = {pos[CNT_W-1:BIT_W] + 1'b1, BIT_W'(0)};
  assign mpos_next_base = {mpos[CNT_W-1:BIT_W] + 1'b1, BIT_W'(0)};

  // Run search across the pages of one word, in ascending order.
  always_comb begin
    logic [CNT_W-1:0] pg;
    scan_run   = run;
    scan_start = run_start;
    scan_found = 1'b0;
    scan_hit   = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      pg = {pos[CNT_W-1:BIT_W], BIT_W'(j)};
      if (!scan_found && pg >= pos && pg < pool) begin
        if (eff_word[j]) begin
          if (scan_run == '0) begin
            scan_start = pg;
          end
          scan_run = scan_run + 1'b1;
          if (scan_run == req_r.page_count) begin
            scan_found = 1'b1;
            scan_hit   = pg;
          end
        end else begin
          scan_run = '0;
        end
      end
    end
  end

  // Word with the part of the run that falls in it overwritten.
  always_comb begin
    logic [CNT_W-1:0] pg;
    for (int j = 0; j < WORD_BITS; j++) begin
      pg = {mpos[CNT_W-1:BIT_W], BIT_W'(j)};
      mark_word[j] = (pg >= mpos && pg < mend) ? mval : eff_word[j];
    end
  end

  assign free_end = {2'b00, req_r.page_number} + {1'b0, req_r.page_count};

  // Search, mark and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (cmd.scan_rd && pos >= pool && pass2) begin
      cursor <= pool;
    end else if (cmd.scan_ev && scan_found) begin
      cursor <= scan_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
      pos   <= cursor;
      run   <= '0;
      pass2 <= 1'b0;
      res   <= '0;
    end else if (cmd.decode) begin
      mpos <= {1'b0, req_r.page_number};
      mend <= free_end[CNT_W-1:0];
      mval <= 1'b1;
      if (req_r.req_type == REQ_FREE && sts.free_bad) begin
        res.status <= ST_RANGE;
      end
    end else if (cmd.scan_rd) begin
      if (pos >= pool) begin
        if (!pass2) begin
          pass2 <= 1'b1;
          pos   <= '0;
          run   <= '0;
        end else begin
          res.status <= ST_NO_SPACE;
        end
      end
    end else if (cmd.scan_ev) begin
      if (scan_found) begin
        res.first_page <= scan_start[PAGE_W-1:0];
        mpos <= scan_start;
        mend <= scan_start + req_r.page_count;
        mval <= 1'b0;
      end else begin
        pos       <= pos_next_base;
        run       <= scan_run;
        run_start <= scan_start;
      end
    end else if (cmd.mark_wr) begin
      mpos <= mpos_next_base;
    end else if (cmd.qry_ev) begin
      res.page_free <= eff_word[req_r.page_number[BIT_W-1:0]];
    end
  end

  // Status toward the controller.
  assign sts.req_type  = req_r.req_type;
  assign sts.free_bad  = free_end > {1'b0, pool};
  assign sts.cnt_zero  = req_r.page_count == '0;
  assign sts.q_oob     = {1'b0, req_r.page_number} >= pool;
  assign sts.pass_end  = pos >= pool;
  assign sts.pass2     = pass2;
  assign sts.found     = scan_found;
  assign sts.mark_last = mpos_next_base >= mend;

  assign rsp = res;

endmodule

/* rtl/bcpa_ctrl.sv */
module bcpa_ctrl import bcpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (sts.req_type)
          REQ_ALLOC: state_next = S_SCAN_RD;
          REQ_FREE:  state_next = (sts.free_bad || sts.cnt_zero) ? S_DONE : S_MARK_RD;
          REQ_QUERY: state_next = sts.q_oob ? S_DONE : S_QRY_RD;
          default:   state_next = S_DONE;
        endcase
      end
      S_SCAN_RD: begin
        if (!sts.pass_end) state_next = S_SCAN_EV;
        else if (sts.pass2) state_next = S_DONE;
      end
      S_SCAN_EV: state_next = sts.found ? S_MARK_RD : S_SCAN_RD;
      S_MARK_RD: state_next = S_MARK_WR;
      S_MARK_WR: state_next = sts.mark_last ? S_DONE : S_MARK_RD;
      S_QRY_RD:  state_next = S_QRY_EV;
      S_QRY_EV:  state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_DECODE:  cmd.decode  = 1'b1;
      S_SCAN_RD: cmd.scan_rd = 1'b1;
      S_SCAN_EV: cmd.scan_ev = 1'b1;
      S_MARK_RD: cmd.mark_rd = 1'b1;
      S_MARK_WR: cmd.mark_wr = 1'b1;
      S_QRY_EV:  cmd.qry_ev  = 1'b1;
      S_DONE:    done        = 1'b1;
      default:   cmd         = '0;
    endcase
  end

endmodule

/* rtl/bitmap_contiguous_page_allocator_unit.sv */
// Next-fit contiguous page allocator over a free bitmap of up to 1024 pages.
// A request is taken when start is high while busy is low; it carries the
// request type (allocate, free, query), a page number and a page count.
// Each request yields exactly one result on rsp, shown for one cycle with
// done high; the receiver cannot stall, so the result must be taken then.
// busy stays high from the cycle after acceptance through the done cycle.
// The bitmap lives in a RAM of 128 rows of 8 pages, read one row at a time.
// An allocate scans from the cursor row by row, then, if no run is found,
// once more from page 0, and marks the run with one read and one write per
// row. A free reads and writes each row it touches; a query reads one row.
// cfg_we writes the pool size (total_pages); the user must do this only
// while the block is idle, as the block itself does not enforce it.
// Reset makes every page free, clears the cursor and sets the pool to 1024
// pages; there is no clearing pass, rows never written read as free.
module bitmap_contiguous_page_allocator_unit import bcpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             req,
  output logic             busy,
  output logic             done,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  bcpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bcpa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request accepted but block not busy");

  // A result ends the request: the block is idle right after it.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done) else $error("block still busy after result");

  // A result only follows a request in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy && $past(busy)) else $error("result without request");

  // A failed allocate reports page zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_NO_SPACE |-> rsp.first_page == '0)
    else $error("no-space result with nonzero first page");

endmodule
